// File: rtl/core/rrtd_pkg.sv
// Package for the round-robin task dispatcher.
// Holds the sizes, command and status codes, flag bits and FSM state type.
// No dependencies.
package rrtd_pkg;

    localparam int TASKS   = 16;
    localparam int IDX_W   = $clog2(TASKS);
    localparam int FUNC_W  = 4;
    localparam int ID_W    = 4;
    localparam int STAT_W  = 3;
    localparam int FLAG_W  = 4;

    localparam logic [ID_W:0] TID_LIM = (ID_W+1)'(TASKS);

    localparam int FL_RDY = 0;
    localparam int FL_WAI = 1;
    localparam int FL_SUS = 2;
    localparam int FL_DMT = 3;

    localparam logic [FLAG_W-1:0] FLAGS_RDY = 4'b0001;
    localparam logic [FLAG_W-1:0] FLAGS_WAI = 4'b0010;
    localparam logic [FLAG_W-1:0] FLAGS_SUS = 4'b0100;
    localparam logic [FLAG_W-1:0] FLAGS_DMT = 4'b1000;

    typedef enum logic [FUNC_W-1:0] {
        FN_REGISTER = 4'd0,
        FN_START    = 4'd1,
        FN_BEGIN    = 4'd2,
        FN_ROTATE   = 4'd3,
        FN_SUSPEND  = 4'd4,
        FN_RESUME   = 4'd5,
        FN_RELEASE  = 4'd6,
        FN_EXIT     = 4'd7,
        FN_QUERY    = 4'd8,
        FN_DISABLE  = 4'd9,
        FN_ENABLE   = 4'd10,
        FN_WAIT     = 4'd11,
        FN_WAKE     = 4'd12
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STS_OK      = 3'd0,
        STS_BADID   = 3'd1,
        STS_NOEXS   = 3'd2,
        STS_STATE   = 3'd3,
        STS_NOSTART = 3'd4,
        STS_NONE    = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

// File: rtl/core/rrtd_if.sv
// Valid/ready channel interfaces for the task dispatcher.
// Command channel and response channel; depends on rrtd_pkg.
interface rrtd_cmd_if import rrtd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic              query_self;

    modport source (output valid, func, task_id, query_self, input ready);
    modport sink   (input valid, func, task_id, query_self, output ready);
endinterface

interface rrtd_rsp_if import rrtd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   current_task;
    logic [ID_W-1:0]   previous_task;
    logic              switched;
    logic [FLAG_W-1:0] task_flags;

    modport source (output valid, status, current_task, previous_task, switched, task_flags,
                    input ready);
    modport sink   (input valid, status, current_task, previous_task, switched, task_flags,
                    output ready);
endinterface

// File: rtl/core/rrtd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds when no read is enabled. No dependencies.
module rrtd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/round_robin_task_dispatcher.sv
// Round-robin task dispatcher: task flag table in RAM plus rotating picker.
// Depends on rrtd_pkg, rrtd_if (rrtd_cmd_if, rrtd_rsp_if) and rrtd_ram.
//
//  channel  | dir | fields
//  ---------+-----+-----------------------------------------------------------
//  i_cmd    | in  | func, task_id, query_self
//  o_rsp    | out | status, current_task, previous_task, switched, task_flags
//
// Each command is handled as a flag table RAM read in IDLE, then modify/write-back
// in EXEC with the rotation search and the response register load.
// A command is taken only in IDLE; the next one is taken once EXEC has finished.
// EXEC holds while a prior response is still waiting on o_rsp.
// Synchronous active-low reset; per-entry valid bits make the table read as 0.
module round_robin_task_dispatcher import rrtd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrtd_cmd_if.sink   i_cmd,
    rrtd_rsp_if.source o_rsp
);

    t_state r_state;
    t_state n_state;

    logic             r_started;
    logic             r_blocked;
    logic [IDX_W-1:0] r_cur;
    logic [TASKS-1:0] r_vld;
    logic [TASKS-1:0] r_run;

    t_func            r_func;
    logic [ID_W-1:0]  r_tid;
    logic             r_self;
    logic [IDX_W-1:0] r_addr;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [ID_W-1:0]   r_out_cur;
    logic [ID_W-1:0]   r_out_prev;
    logic              r_out_sw;
    logic [FLAG_W-1:0] r_out_flags;

    logic             cmd_ready;
    logic             accept;
    logic             exec_go;
    logic [IDX_W-1:0] in_addr;
    logic [FLAG_W-1:0] ram_rdata;

    logic [FLAG_W-1:0] f;
    logic              tid_ok;
    logic              wr_en;
    logic [FLAG_W-1:0] wr_data;
    t_status           st;
    logic              do_rot;
    logic              rot_stat;
    logic              start;
    logic              n_blocked;
    logic [FLAG_W-1:0] flags_out;

    logic [TASKS-1:0]   run_upd;
    logic [2*TASKS-1:0] dbl;
    logic [TASKS-1:0]   rot;
    logic [IDX_W:0]     sh;
    logic [IDX_W-1:0]   pick;
    logic [IDX_W:0]     sum;
    logic [IDX_W-1:0]   rot_id;
    logic               found;
    logic [IDX_W-1:0]   n_cur;
    logic               sw;
    t_status            n_status;

    // FSM
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready = 1'b0;
        exec_go   = 1'b0;
        unique case (r_state)
            S_IDLE: cmd_ready = 1'b1;
            S_EXEC: exec_go   = !r_out_valid || o_rsp.ready;
            default: begin
                cmd_ready = 1'b0;
                exec_go   = 1'b0;
            end
        endcase
    end

    assign i_cmd.ready = cmd_ready;
    assign accept      = i_cmd.valid && cmd_ready;

    assign in_addr = (i_cmd.func == FN_EXIT || i_cmd.func == FN_WAIT ||
                      (i_cmd.func == FN_QUERY && i_cmd.query_self))
                     ? r_cur : i_cmd.task_id[IDX_W-1:0];

    rrtd_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (TASKS)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (exec_go && wr_en),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Command decode and flag update
    assign f      = r_vld[r_addr] ? ram_rdata : '0;
    assign tid_ok = {1'b0, r_tid} < TID_LIM;

    always_comb begin
        wr_en     = 1'b0;
        wr_data   = f;
        st        = STS_OK;
        do_rot    = 1'b0;
        rot_stat  = 1'b0;
        start     = 1'b0;
        n_blocked = r_blocked;
        flags_out = '0;
        case (r_func) inside
            FN_REGISTER, FN_START, FN_BEGIN, FN_SUSPEND, FN_RESUME, FN_RELEASE,
            FN_WAKE: begin
                if (!tid_ok) begin
                    st = STS_BADID;
                end else begin
                    case (r_func)
                        FN_REGISTER: begin
                            wr_en   = 1'b1;
                            wr_data = FLAGS_DMT;
                        end
                        FN_START: begin
                            wr_en   = 1'b1;
                            wr_data = FLAGS_RDY;
                        end
                        FN_BEGIN: begin
                            if (f != FLAGS_RDY) begin
                                st = STS_NOSTART;
                            end else begin
                                start = 1'b1;
                            end
                        end
                        FN_WAKE: begin
                            wr_en   = 1'b1;
                            wr_data = (f & ~FLAGS_WAI) | FLAGS_RDY;
                        end
                        default: begin
                            if (f == '0) begin
                                st = STS_NOEXS;
                            end else if (r_func == FN_SUSPEND) begin
                                wr_en   = 1'b1;
                                wr_data = f | FLAGS_SUS;
                                do_rot  = (r_tid[IDX_W-1:0] == r_cur);
                            end else if (r_func == FN_RESUME) begin
                                if (!(f[FL_WAI] || f[FL_SUS])) begin
                                    st = STS_STATE;
                                end else begin
                                    wr_en   = 1'b1;
                                    wr_data = f & ~FLAGS_SUS;
                                    do_rot  = 1'b1;
                                end
                            end else begin
                                if (!f[FL_WAI]) begin
                                    st = STS_STATE;
                                end else begin
                                    wr_en   = 1'b1;
                                    wr_data = f & ~FLAGS_WAI;
                                end
                            end
                        end
                    endcase
                end
            end
            FN_ROTATE: begin
                do_rot   = 1'b1;
                rot_stat = 1'b1;
            end
            FN_EXIT: begin
                wr_en    = 1'b1;
                wr_data  = FLAGS_DMT;
                do_rot   = 1'b1;
                rot_stat = 1'b1;
            end
            FN_QUERY: begin
                if (r_self || tid_ok) begin
                    flags_out = f;
                end else begin
                    st = STS_NOEXS;
                end
            end
            FN_DISABLE: n_blocked = 1'b1;
            FN_ENABLE:  n_blocked = 1'b0;
            FN_WAIT: begin
                wr_en   = 1'b1;
                wr_data = FLAGS_WAI;
                do_rot  = 1'b1;
            end
            default: begin
                st = STS_OK;
            end
        endcase
    end

    // Rotating priority pick, starting at current+1
    always_comb begin
        run_upd = r_run;
        if (wr_en) begin
            run_upd[r_addr] = !wr_data[FL_SUS] && (wr_data[FL_RDY] || wr_data[FL_WAI]);
        end
        sh    = {1'b0, r_cur} + (IDX_W+1)'(1);
        dbl   = {run_upd, run_upd} >> sh;
        rot   = dbl[TASKS-1:0];
        found = |rot;
        pick  = '0;
        for (int i = TASKS - 1; i >= 0; i--) begin
            if (rot[i]) begin
                pick = IDX_W'(i);
            end
        end
        sum = sh + {1'b0, pick};
        if (sum >= (IDX_W+1)'(TASKS)) begin
            sum = sum - (IDX_W+1)'(TASKS);
        end
        rot_id = sum[IDX_W-1:0];
    end

    always_comb begin
        n_cur    = r_cur;
        sw       = 1'b0;
        n_status = st;
        if (start) begin
            n_cur = r_tid[IDX_W-1:0];
            sw    = 1'b1;
        end
        if (do_rot && r_started && !r_blocked) begin
            if (found) begin
                n_cur = rot_id;
                sw    = 1'b1;
            end else if (rot_stat) begin
                n_status = STS_NONE;
            end
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_blocked   <= 1'b0;
            r_cur       <= '0;
            r_vld       <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_started <= r_started || start;
                r_blocked <= n_blocked;
                r_cur     <= n_cur;
                r_run     <= run_upd;
                if (wr_en) begin
                    r_vld[r_addr] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_cmd.func);
            r_tid  <= i_cmd.task_id;
            r_self <= i_cmd.query_self;
            r_addr <= in_addr;
        end
        if (exec_go) begin
            r_out_status <= n_status;
            r_out_cur    <= ID_W'(n_cur);
            r_out_prev   <= ID_W'(r_cur);
            r_out_sw     <= sw;
            r_out_flags  <= flags_out;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.current_task  = r_out_cur;
    assign o_rsp.previous_task = r_out_prev;
    assign o_rsp.switched      = r_out_sw;
    assign o_rsp.task_flags    = r_out_flags;

`ifndef SYNTH
    a_ram_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && wr_en) |-> (r_state == S_EXEC))
        else $error("flag table written outside EXEC");

    a_cur_change_switched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != $past(r_cur)) |-> (r_out_valid && r_out_sw))
        else $error("current task changed without a reported switch");

    a_switch_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sw) |-> (r_out_status == STS_OK))
        else $error("switch reported with error status");

    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("response raised without a command in EXEC");
`endif

endmodule
